@@ rtl/plsp_pkg.sv @@
`default_nettype none

package plsp_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int TIME_W   = 16;
    localparam int TEMP_W   = 16;
    localparam int STATUS_W = 2;

    // default table depth
    localparam int MAX_POINTS_DEF = 16;

    // serial divider: 32-bit magnitude dividend, 16-bit divisor
    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = TIME_W;
    localparam int DIV_STEPS = DIV_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

endpackage

`default_nettype wire

@@ rtl/plsp_div.sv @@
`default_nettype none

module plsp_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [plsp_pkg::DIV_W-1:0]         dividend,
    input  wire logic [plsp_pkg::DIVISOR_W-1:0]     divisor,
    output logic                                    busy,
    output logic                                    done,
    output logic [plsp_pkg::DIV_W-1:0]              quotient
);

    localparam int STEP_CNT_W = $clog2(plsp_pkg::DIV_STEPS);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [STEP_CNT_W-1:0]             cnt_reg, cnt_next;
    logic [plsp_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [plsp_pkg::DIV_W-1:0]        quo_reg, quo_next;
    logic [plsp_pkg::DIVISOR_W:0]      trial;
    logic                              fits;

    // one restoring step per cycle, dividend bits shift out as quotient bits shift in
    always_comb
    begin
        trial     = {rem_reg, quo_reg[plsp_pkg::DIV_W-1]};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = plsp_pkg::DIVISOR_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[plsp_pkg::DIVISOR_W-1:0];
            end
            quo_next = {quo_reg[plsp_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_W'(plsp_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ rtl/piecewise_linear_setpoint_core.sv @@
`default_nettype none

// channel   dir  handshake           payload
// s_        in   s_tvalid/s_tready   tdata: time_point, temp_point; tuser: cmd
// m_        out  m_tvalid/m_tready   tdata: temp_value, end_time; tuser: status
//
// clear, append, unused commands and a query on an empty table go from idle straight to the done state
// a query reads the first point, then fetches and compares one segment at a time
// (one table read port), then multiplies and runs the 32-step divider when the time falls inside a segment
// s_tready is high only when idle
// the result sits in an output register; a stalled m_tready holds only the next result
// reset empties the table at once; stored breakpoints need no clearing pass

module piecewise_linear_setpoint_core #(
    parameter int MAX_POINTS = plsp_pkg::MAX_POINTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] time_point, [31:16] temp_point
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] temp_value, [31:16] end_time
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int TIME_W  = plsp_pkg::TIME_W;
    localparam int TEMP_W  = plsp_pkg::TEMP_W;
    localparam int ENTRY_W = TIME_W + TEMP_W;
    localparam int PROD_W  = 2 * (TEMP_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_LOAD0,
        ST_STEP,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [TIME_W-1:0]                last_time_reg, last_time_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [TIME_W-1:0]                qtime_reg, qtime_next;
    logic [TIME_W-1:0]                t0_reg, t0_next;
    logic signed [TEMP_W-1:0]         p0_reg, p0_next;
    logic [TIME_W-1:0]                dt_reg, dt_next;
    logic [TIME_W-1:0]                dtime_reg, dtime_next;
    logic signed [TEMP_W:0]           dtemp_reg, dtemp_next;
    logic [plsp_pkg::DIV_W-1:0]       mag_reg, mag_next;
    logic                             neg_reg, neg_next;
    logic [plsp_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [TEMP_W-1:0]                res_temp_reg, res_temp_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [plsp_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [TEMP_W-1:0]                out_temp_reg, out_temp_next;
    logic [TIME_W-1:0]                out_end_reg, out_end_next;

    // breakpoint store, {temp, time} per entry
    logic [ENTRY_W-1:0]               mem [MAX_POINTS];
    logic [ENTRY_W-1:0]               rd_data_reg;
    logic [IDX_W-1:0]                 rd_addr;
    logic                             wr_en;

    logic [plsp_pkg::CMD_W-1:0]       in_cmd;
    logic [TIME_W-1:0]                in_time;
    logic [TEMP_W-1:0]                in_temp;
    logic [TIME_W-1:0]                rd_time;
    logic signed [TEMP_W-1:0]         rd_temp;
    logic [CNT_W-1:0]                 next_pos;
    logic signed [PROD_W-1:0]         prod;
    logic signed [PROD_W-1:0]         prod_abs;
    logic signed [TEMP_W+1:0]         q_signed;
    logic signed [TEMP_W+1:0]         interp_sum;

    logic                             div_start;
    logic                             div_busy;
    logic                             div_done;
    logic [plsp_pkg::DIV_W-1:0]       div_quo;

    assign in_cmd   = s_tuser;
    assign in_time  = s_tdata[TIME_W-1:0];
    assign in_temp  = s_tdata[ENTRY_W-1:TIME_W];
    assign rd_time  = rd_data_reg[TIME_W-1:0];
    assign rd_temp  = $signed(rd_data_reg[ENTRY_W-1:TIME_W]);
    assign next_pos = CNT_W'(idx_reg) + 1'b1;

    // serial divider for the interpolation quotient
    plsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (dtime_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_time_next  = last_time_reg;
        idx_next        = idx_reg;
        qtime_next      = qtime_reg;
        t0_next         = t0_reg;
        p0_next         = p0_reg;
        dt_next         = dt_reg;
        dtime_next      = dtime_reg;
        dtemp_next      = dtemp_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        res_status_next = res_status_reg;
        res_temp_next   = res_temp_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_status_next = out_status_reg;
        out_temp_next   = out_temp_reg;
        out_end_next    = out_end_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        div_start       = 1'b0;
        prod            = $signed({1'b0, dt_reg}) * dtemp_reg;
        prod_abs        = prod[PROD_W-1] ? -prod : prod;
        q_signed        = neg_reg ? -$signed({1'b0, div_quo[TEMP_W:0]})
                                  : $signed({1'b0, div_quo[TEMP_W:0]});
        interp_sum      = q_signed + (TEMP_W+2)'(p0_reg);

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_status_next = plsp_pkg::STATUS_OK;
                    res_temp_next   = '0;
                    state_next      = ST_DONE;
                    case (in_cmd)
                        plsp_pkg::CMD_CLEAR:
                        begin
                            count_next     = '0;
                            last_time_next = '0;
                        end
                        plsp_pkg::CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_POINTS))
                            begin
                                wr_en          = 1'b1;
                                count_next     = count_reg + 1'b1;
                                last_time_next = in_time;
                            end
                            else
                            begin
                                res_status_next = plsp_pkg::STATUS_FULL;
                            end
                        end
                        plsp_pkg::CMD_QUERY:
                        begin
                            qtime_next = in_time;
                            if (count_reg == '0)
                            begin
                                res_status_next = plsp_pkg::STATUS_OUTSIDE;
                            end
                            else
                            begin
                                state_next = ST_RD0;
                            end
                        end
                        default:
                        begin
                            res_status_next = plsp_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ST_RD0:
            begin
                rd_addr    = '0;
                state_next = ST_LOAD0;
            end
            ST_LOAD0:
            begin
                t0_next    = rd_time;
                p0_next    = rd_temp;
                idx_next   = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // fetch the segment's right end, or check the last point alone
                rd_addr = IDX_W'(next_pos);
                if (next_pos < count_reg)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                    if (qtime_reg == t0_reg)
                    begin
                        res_status_next = plsp_pkg::STATUS_OK;
                        res_temp_next   = p0_reg;
                    end
                    else
                    begin
                        res_status_next = plsp_pkg::STATUS_OUTSIDE;
                        res_temp_next   = '0;
                    end
                end
            end
            ST_CMP:
            begin
                if (qtime_reg == t0_reg)
                begin
                    res_status_next = plsp_pkg::STATUS_OK;
                    res_temp_next   = p0_reg;
                    state_next      = ST_DONE;
                end
                else if (qtime_reg > t0_reg && qtime_reg < rd_time)
                begin
                    dt_next    = qtime_reg - t0_reg;
                    dtime_next = rd_time - t0_reg;
                    dtemp_next = (TEMP_W+1)'(rd_temp) - (TEMP_W+1)'(p0_reg);
                    state_next = ST_MUL;
                end
                else
                begin
                    t0_next    = rd_time;
                    p0_next    = rd_temp;
                    idx_next   = IDX_W'(next_pos);
                    state_next = ST_STEP;
                end
            end
            ST_MUL:
            begin
                neg_next   = prod[PROD_W-1];
                mag_next   = prod_abs[plsp_pkg::DIV_W-1:0];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // divider sees the product magnitude registered last cycle
                if (!div_busy && !div_done)
                begin
                    div_start = 1'b1;
                end
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                res_status_next = plsp_pkg::STATUS_OK;
                res_temp_next   = interp_sum[TEMP_W-1:0];
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_temp_next   = res_temp_reg;
                    out_end_next    = last_time_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            last_time_reg  <= '0;
            idx_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            qtime_reg      <= '0;
            t0_reg         <= '0;
            p0_reg         <= '0;
            dt_reg         <= '0;
            dtime_reg      <= '0;
            dtemp_reg      <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            res_status_reg <= plsp_pkg::STATUS_OK;
            res_temp_reg   <= '0;
            out_status_reg <= plsp_pkg::STATUS_OK;
            out_temp_reg   <= '0;
            out_end_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_time_reg  <= last_time_next;
            idx_reg        <= idx_next;
            m_tvalid_reg   <= m_tvalid_next;
            qtime_reg      <= qtime_next;
            t0_reg         <= t0_next;
            p0_reg         <= p0_next;
            dt_reg         <= dt_next;
            dtime_reg      <= dtime_next;
            dtemp_reg      <= dtemp_next;
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            res_status_reg <= res_status_next;
            res_temp_reg   <= res_temp_next;
            out_status_reg <= out_status_next;
            out_temp_reg   <= out_temp_next;
            out_end_reg    <= out_end_next;
        end
    end

    // breakpoint memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= {in_temp, in_time};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_end_reg, out_temp_reg};
    assign m_tuser  = out_status_reg;

    // fill count never passes the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("breakpoint count beyond table depth");

    // a full flag only comes from a full table
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_status_reg == plsp_pkg::STATUS_FULL)
        |-> count_reg == CNT_W'(MAX_POINTS))
        else $error("table full reported while table has room");

    // an empty table reports no end time
    a_empty_end_time: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (last_time_reg == '0))
        else $error("end time nonzero on empty table");

    // an outside query carries a zero setpoint
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == plsp_pkg::STATUS_OUTSIDE) |-> (m_tdata[15:0] == '0))
        else $error("outside query with nonzero setpoint");

endmodule

`default_nettype wire

@@ tb/piecewise_linear_setpoint_core_test.sv @@
`timescale 1ns / 100ps

module piecewise_linear_setpoint_core_test;

    import plsp_pkg::*;

    // command value with no meaning; the block just reports the table
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int TABLE_DEPTH   = MAX_POINTS_DEF;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TEMP_W-1:0]   value;
        logic [TIME_W-1:0]   end_time;
    } setpoint_result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] time_point;
        logic [TEMP_W-1:0] temp_point;
        int                reps;
        bit                typed;
        setpoint_result_t  res;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // [15:0] time_point, [31:16] temp_point
    logic [1:0]  s_tuser  = '0;  // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [15:0] temp_value, [31:16] end_time
    logic [1:0]  m_tuser;        // [1:0] status

    // predictor copy of the breakpoint table
    logic [TIME_W-1:0] profile_times [TABLE_DEPTH];
    logic [TEMP_W-1:0] profile_temps [TABLE_DEPTH];
    int                profile_len = 0;

    setpoint_result_t pending_setpoints[$];
    stim_row_t        directed_rows[$];

    int  mismatch_count = 0;
    int  burst_left     = 0;
    int  idle_cycles    = 0;
    int  results_seen   = 0;
    bit  random_phase   = 1'b0;
    int  n_clear = 0, n_append = 0, n_full = 0, n_unused = 0;
    int  n_exact = 0, n_interp = 0, n_outside = 0;

    piecewise_linear_setpoint_core #(
        .MAX_POINTS(TABLE_DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 clk = ~clk;

    // one line per mismatch, counted
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // apply one transaction to the predicted table and work out its result
    task automatic predict_setpoint(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                                    input logic [TEMP_W-1:0] tp, output setpoint_result_t res);
        longint p0;
        longint p1;
        longint dt;
        longint dtime;
        longint val;
        bit     found;
        res   = '0;
        val   = 0;
        found = 1'b0;
        case (cmd)
            CMD_CLEAR:
            begin
                profile_len = 0;
                n_clear++;
            end
            CMD_APPEND:
            begin
                n_append++;
                if (profile_len < TABLE_DEPTH)
                begin
                    profile_times[profile_len] = t;
                    profile_temps[profile_len] = tp;
                    profile_len++;
                end
                else
                begin
                    res.status = STATUS_FULL;
                    n_full++;
                end
            end
            CMD_QUERY:
            begin
                // first exact hit or first segment strictly holding the time
                for (int i = 0; i + 1 < profile_len && !found; i++)
                begin
                    if (t == profile_times[i])
                    begin
                        val   = longint'($signed(profile_temps[i]));
                        found = 1'b1;
                        n_exact++;
                    end
                    else if (t > profile_times[i] && t < profile_times[i+1])
                    begin
                        p0    = longint'($signed(profile_temps[i]));
                        p1    = longint'($signed(profile_temps[i+1]));
                        dt    = longint'(t) - longint'(profile_times[i]);
                        dtime = longint'(profile_times[i+1]) - longint'(profile_times[i]);
                        val   = p0 + (dt * (p1 - p0)) / dtime;
                        found = 1'b1;
                        n_interp++;
                    end
                end
                // the last breakpoint matches on its exact time too
                if (!found && profile_len > 0 && t == profile_times[profile_len-1])
                begin
                    val   = longint'($signed(profile_temps[profile_len-1]));
                    found = 1'b1;
                    n_exact++;
                end
                if (found)
                    res.value = val[TEMP_W-1:0];
                else
                begin
                    res.status = STATUS_OUTSIDE;
                    n_outside++;
                end
            end
            default:
                n_unused++;
        endcase
        res.end_time = (profile_len > 0) ? profile_times[profile_len-1] : '0;
    endtask

    // offer one transaction in bursts with random gaps; entered and left at a falling edge
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                             input logic [TEMP_W-1:0] tp, input bit typed,
                             input setpoint_result_t typed_res);
        setpoint_result_t predicted;
        int               gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tp, t};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_setpoint(cmd, t, tp, predicted);
        pending_setpoints.push_back(typed ? typed_res : predicted);
        burst_left--;
        @(negedge clk);
    endtask

    // hold the input until every expected result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_setpoints.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                           input logic [TEMP_W-1:0] tp, input int reps, input bit typed,
                           input logic [STATUS_W-1:0] st, input logic [TEMP_W-1:0] val,
                           input logic [TIME_W-1:0] end_t);
        stim_row_t row;
        row.cmd        = cmd;
        row.time_point = t;
        row.temp_point = tp;
        row.reps       = reps;
        row.typed      = typed;
        row.res        = '{status: st, value: val, end_time: end_t};
        directed_rows.push_back(row);
    endtask

    // result checker
    always @(posedge clk)
    begin
        setpoint_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_setpoints.size() == 0)
                report_mismatch($sformatf("result with nothing expected: status %0d data %h",
                                          m_tuser, m_tdata));
            else
            begin
                exp_res = pending_setpoints.pop_front();
                if (m_tuser !== exp_res.status)
                    report_mismatch($sformatf("status: expected %0d, got %0d",
                                              exp_res.status, m_tuser));
                if (m_tdata[15:0] !== exp_res.value)
                    report_mismatch($sformatf("temp_value: expected %0d, got %0d",
                                              $signed(exp_res.value), $signed(m_tdata[15:0])));
                if (m_tdata[31:16] !== exp_res.end_time)
                    report_mismatch($sformatf("end_time: expected %0d, got %0d",
                                              exp_res.end_time, m_tdata[31:16]));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // receiver: phases of full rate, random stalls, solid stalls, and one long hold-off
    initial
    begin
        int  mode;
        int  len;
        bit  held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(4, 40);
            if (!held_off && random_phase && results_seen > 100)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge clk);
                held_off = 1'b1;
            end
            else
            begin
                repeat (len)
                begin
                    if (mode < 3)
                        m_tready <= 1'b1;
                    else if (mode == 3)
                        m_tready <= 1'b0;
                    else
                        m_tready <= ($urandom_range(0, 3) != 0);
                    @(negedge clk);
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        stim_row_t         row;
        logic [TIME_W-1:0] t;
        logic [TEMP_W-1:0] tp;
        logic [CMD_W-1:0]  cmd;
        int                counted;
        int                n_points;
        int                n_queries;
        int                t_acc;
        int                idx;
        int                lo;
        int                hi;
        int                mode;
        bit                wide;

        // empty table, one-point table, full-range segment, unused command
        add_row(CMD_QUERY,  16'd0,     16'd0,     1, 1, STATUS_OUTSIDE, 16'd0,     16'd0);
        add_row(CMD_APPEND, 16'd0,     16'h8000,  1, 1, STATUS_OK,      16'd0,     16'd0);
        add_row(CMD_QUERY,  16'd0,     16'd0,     1, 1, STATUS_OK,      16'h8000,  16'd0);
        add_row(CMD_QUERY,  16'd1,     16'd0,     1, 1, STATUS_OUTSIDE, 16'd0,     16'd0);
        add_row(CMD_UNUSED, 16'hFFFF,  16'hFFFF,  1, 1, STATUS_OK,      16'd0,     16'd0);
        add_row(CMD_APPEND, 16'hFFFF,  16'h7FFF,  1, 1, STATUS_OK,      16'd0,     16'hFFFF);
        add_row(CMD_QUERY,  16'hFFFF,  16'd0,     1, 1, STATUS_OK,      16'h7FFF,  16'hFFFF);
        add_row(CMD_QUERY,  16'h8000,  16'd0,     1, 0, STATUS_OK,      16'd0,     16'd0);
        add_row(CMD_QUERY,  16'hFFFE,  16'd0,     1, 0, STATUS_OK,      16'd0,     16'd0);
        add_row(CMD_CLEAR,  16'd0,     16'd0,     1, 1, STATUS_OK,      16'd0,     16'd0);
        // duplicate and unsorted breakpoints
        add_row(CMD_APPEND, 16'd100,   16'd160,   1, 1, STATUS_OK,      16'd0,     16'd100);
        add_row(CMD_APPEND, 16'd100,   -16'sd50,  1, 1, STATUS_OK,      16'd0,     16'd100);
        add_row(CMD_APPEND, 16'd50,    16'd800,   1, 1, STATUS_OK,      16'd0,     16'd50);
        add_row(CMD_QUERY,  16'd100,   16'd0,     1, 1, STATUS_OK,      16'd160,   16'd50);
        add_row(CMD_QUERY,  16'd75,    16'd0,     1, 1, STATUS_OUTSIDE, 16'd0,     16'd50);
        add_row(CMD_QUERY,  16'd50,    16'd0,     1, 1, STATUS_OK,      16'd800,   16'd50);
        // fill the table, then append once more to a full table
        add_row(CMD_APPEND, 16'd200,   -16'sd1234, 13, 0, STATUS_OK,    16'd0,     16'd0);
        add_row(CMD_APPEND, 16'd60000, 16'd5,     1, 1, STATUS_FULL,    16'd0,     16'd49352);
        add_row(CMD_QUERY,  16'd2000,  16'd0,     1, 0, STATUS_OK,      16'd0,     16'd0);
        add_row(CMD_QUERY,  16'd4299,  16'd0,     1, 0, STATUS_OK,      16'd0,     16'd0);
        add_row(CMD_QUERY,  16'd49353, 16'd0,     1, 1, STATUS_OUTSIDE, 16'd0,     16'd49352);
        add_row(CMD_CLEAR,  16'd0,     16'd0,     1, 1, STATUS_OK,      16'd0,     16'd0);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++)
            begin
                t  = row.time_point + TIME_W'(k * 4096);
                tp = (k % 2 == 1) ? -row.temp_point : row.temp_point;
                send_item(row.cmd, t, tp, row.typed, row.res);
            end
        end
        drain_results();
        random_phase = 1'b1;

        // random profiles followed by queries, with some noise sequences
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat (6)
                begin
                    cmd = CMD_W'($urandom_range(0, 3));
                    send_item(cmd, TIME_W'($urandom), TEMP_W'($urandom), 1'b0, '0);
                    if (cmd != CMD_UNUSED)
                        counted++;
                end
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    send_item(CMD_CLEAR, TIME_W'($urandom), TEMP_W'($urandom), 1'b0, '0);
                    counted++;
                end
                n_points = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 19)
                                                       : $urandom_range(1, 8);
                wide     = ($urandom_range(0, 3) != 0);
                t_acc    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 200);
                repeat (n_points)
                begin
                    send_item(CMD_APPEND, TIME_W'(t_acc), TEMP_W'($urandom), 1'b0, '0);
                    counted++;
                    t_acc += wide ? $urandom_range(1, 65535 / n_points) : $urandom_range(0, 3);
                    if (t_acc > 65535)
                        t_acc = 65535;
                end
                n_queries = $urandom_range(4, 24);
                repeat (n_queries)
                begin
                    mode = $urandom_range(0, 9);
                    t    = TIME_W'($urandom);
                    if (mode < 3 && profile_len > 0)
                    begin
                        idx = $urandom_range(0, profile_len - 1);
                        t   = profile_times[idx];
                    end
                    else if (mode < 7 && profile_len > 1)
                    begin
                        idx = $urandom_range(0, profile_len - 2);
                        lo  = profile_times[idx];
                        hi  = profile_times[idx+1];
                        if (hi > lo + 1)
                            t = TIME_W'($urandom_range(lo + 1, hi - 1));
                    end
                    else if (mode == 9)
                        t = ($urandom_range(0, 1) == 1) ? '1 : '0;
                    send_item(CMD_QUERY, t, TEMP_W'($urandom), 1'b0, '0);
                    counted++;
                end
            end
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        s_tvalid <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d results: %0d clears, %0d appends (%0d to a full table), %0d unused",
                 results_seen, n_clear, n_append, n_full, n_unused);
        $display("queries: %0d on a breakpoint, %0d interpolated, %0d outside the profile",
                 n_exact, n_interp, n_outside);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
